// File: hdl/cau_pkg.sv
package cau_pkg;

    // Operation codes carried in the mode field
    localparam logic [2:0] MODE_ADD  = 3'd0;
    localparam logic [2:0] MODE_SUB  = 3'd1;
    localparam logic [2:0] MODE_MUL  = 3'd2;
    localparam logic [2:0] MODE_DIV  = 3'd3;
    localparam logic [2:0] MODE_NEG  = 3'd4;
    localparam logic [2:0] MODE_CONJ = 3'd5;

    // Divider shape: quotient bits, bits retired per stage, stage count
    localparam int QUO_W      = 32;
    localparam int DIV_STEPS  = 2;
    localparam int DIV_STAGES = QUO_W / DIV_STEPS;

    typedef struct packed {
        logic [2:0]         mode;
        logic signed [31:0] a_re;
        logic signed [31:0] a_im;
        logic signed [31:0] b_re;
        logic signed [31:0] b_im;
    } t_in;

    typedef struct packed {
        logic signed [31:0] res_re;
        logic signed [31:0] res_im;
        logic               div_by_zero;
        logic               overflow;
    } t_out;

endpackage

// File: hdl/cau_div.sv
module cau_div import cau_pkg::*; (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [63:0]       i_num,
    input  logic [63:0]       i_den,
    output logic [QUO_W-1:0]  o_quo,
    output logic              o_sat
);

    typedef struct packed {
        logic [63:0]      rem;
        logic [63:0]      den;
        logic [31:0]      x;
        logic [QUO_W-1:0] q;
        logic             sat;
    } t_dst;

    t_dst r_st [DIV_STAGES];
    t_dst n_st [DIV_STAGES];

    // Restoring division of num * 2^16 by den, a fixed number of bits per stage
    always_comb begin
        t_dst        v;
        logic [63:0] t;
        for (int k = 0; k < DIV_STAGES; k++) begin
            if (k == 0) begin
                v.rem = {16'h0, i_num[63:16]};
                v.den = i_den;
                v.x   = {i_num[15:0], 16'h0};
                v.q   = '0;
                v.sat = ({16'h0, i_num} >= {i_den, 16'h0});
            end else begin
                v = r_st[k-1];
            end
            for (int j = 0; j < DIV_STEPS; j++) begin
                t   = {v.rem[62:0], v.x[31]};
                v.x = {v.x[30:0], 1'b0};
                if (t >= v.den) begin
                    v.rem = t - v.den;
                    v.q   = {v.q[QUO_W-2:0], 1'b1};
                end else begin
                    v.rem = t;
                    v.q   = {v.q[QUO_W-2:0], 1'b0};
                end
            end
            n_st[k] = v;
        end
    end

    // Advance all stages together
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < DIV_STAGES; k++) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    assign o_quo = r_st[DIV_STAGES-1].q;
    assign o_sat = r_st[DIV_STAGES-1].sat;

endmodule

// File: hdl/complex_arith_unit_top.sv
// Complex arithmetic unit, signed Q16.16 operands and results.
// Input channel: i_valid / o_stall with payload i_data (mode, a, b).
// Output channel: o_valid / i_stall with payload o_data (result and flags).
// A transfer happens at a rising edge where valid is high and stall is low.
// Modes: add, subtract, multiply, divide, negate a, conjugate a.
// Throughput: one item per cycle unless the output stalls; a new item may follow in the next cycle.
// Pipeline: a result passes one stage of products, one of sums, one of
// magnitudes, 16 divider stages retiring two quotient bits each, and the
// output register. Every mode takes this path.
// When the receiver stalls a shown result, the whole pipe holds and o_stall
// rises; nothing is lost or repeated. Bubbles travel with their valid bits.
// Reset (i_rst_n low, synchronous) clears all valid bits; data registers
// are not reset. The unit keeps no state between items.
module complex_arith_unit_top import cau_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_stall,
    output t_out o_data
);

    localparam int VLD_LEN = DIV_STAGES + 4;

    typedef struct packed {
        logic [2:0]  mode;
        logic        neg_re;
        logic [63:0] mag_re;
        logic        neg_im;
        logic [63:0] mag_im;
        logic        dz;
    } t_side;

    logic               w_en;
    logic [VLD_LEN-1:0] r_vld;

    logic [2:0]         r1_mode;
    logic signed [31:0] r1_ar, r1_ai, r1_br, r1_bi;
    logic signed [63:0] r1_prr, r1_pii, r1_pri, r1_pir, r1_pbr, r1_pbi;

    logic [2:0]         r2_mode;
    logic signed [64:0] r2_re, r2_im, n2_re, n2_im;
    logic [63:0]        r2_den;

    t_side              r3_side, n3_side;
    logic [64:0]        w3_abs_re, w3_abs_im;
    logic [63:0]        r3_den;

    t_side              r_side [DIV_STAGES];
    logic [QUO_W-1:0]   w_quo_re, w_quo_im;
    logic               w_sat_re, w_sat_im;

    logic [63:0]        w_fmag_re, w_fmag_im;
    logic [32:0]        w_sat_out_re, w_sat_out_im;
    t_out               r_out;

    function automatic logic [32:0] sat32(input logic neg, input logic [63:0] mag);
        logic [32:0] res;
        if (!neg) begin
            if (mag > 64'h7FFF_FFFF) res = {1'b1, 32'h7FFF_FFFF};
            else                     res = {1'b0, mag[31:0]};
        end else begin
            if (mag > 64'h8000_0000) res = {1'b1, 32'h8000_0000};
            else                     res = {1'b0, 32'(-mag[31:0])};
        end
        return res;
    endfunction

    // Hold the whole pipe while a shown result is stalled
    assign w_en    = !(r_vld[VLD_LEN-1] && i_stall);
    assign o_stall = !w_en;
    assign o_valid = r_vld[VLD_LEN-1];
    assign o_data  = r_out;

    // Advance valid bits with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[VLD_LEN-2:0], i_valid};
        end
    end

    // Stage 1: register operands and form all products
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_mode <= i_data.mode;
            r1_ar   <= i_data.a_re;
            r1_ai   <= i_data.a_im;
            r1_br   <= i_data.b_re;
            r1_bi   <= i_data.b_im;
            r1_prr  <= i_data.a_re * i_data.b_re;
            r1_pii  <= i_data.a_im * i_data.b_im;
            r1_pri  <= i_data.a_re * i_data.b_im;
            r1_pir  <= i_data.a_im * i_data.b_re;
            r1_pbr  <= i_data.b_re * i_data.b_re;
            r1_pbi  <= i_data.b_im * i_data.b_im;
        end
    end

    // Stage 2: exact sums per mode
    always_comb begin
        unique case (r1_mode)
            MODE_ADD: begin
                n2_re = 65'(r1_ar) + 65'(r1_br);
                n2_im = 65'(r1_ai) + 65'(r1_bi);
            end
            MODE_SUB: begin
                n2_re = 65'(r1_ar) - 65'(r1_br);
                n2_im = 65'(r1_ai) - 65'(r1_bi);
            end
            MODE_MUL: begin
                n2_re = 65'(r1_prr) - 65'(r1_pii);
                n2_im = 65'(r1_pri) + 65'(r1_pir);
            end
            MODE_DIV: begin
                n2_re = 65'(r1_prr) + 65'(r1_pii);
                n2_im = 65'(r1_pir) - 65'(r1_pri);
            end
            MODE_NEG: begin
                n2_re = -65'(r1_ar);
                n2_im = -65'(r1_ai);
            end
            MODE_CONJ: begin
                n2_re = 65'(r1_ar);
                n2_im = -65'(r1_ai);
            end
            default: begin
                n2_re = '0;
                n2_im = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_mode <= r1_mode;
            r2_re   <= n2_re;
            r2_im   <= n2_im;
            r2_den  <= $unsigned(r1_pbr) + $unsigned(r1_pbi);
        end
    end

    // Stage 3: split into sign and magnitude, truncate products toward zero
    assign w3_abs_re = r2_re[64] ? -r2_re : r2_re;
    assign w3_abs_im = r2_im[64] ? -r2_im : r2_im;

    always_comb begin
        n3_side.mode   = r2_mode;
        n3_side.neg_re = r2_re[64];
        n3_side.neg_im = r2_im[64];
        if (r2_mode == MODE_MUL) begin
            n3_side.mag_re = {16'h0, w3_abs_re[63:16]};
            n3_side.mag_im = {16'h0, w3_abs_im[63:16]};
        end else begin
            n3_side.mag_re = w3_abs_re[63:0];
            n3_side.mag_im = w3_abs_im[63:0];
        end
        n3_side.dz = (r2_mode == MODE_DIV) && (r2_den == 64'h0);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_side <= n3_side;
            r3_den  <= r2_den;
        end
    end

    // Divider lanes for the real and imaginary quotients
    cau_div u_div_re (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r3_side.mag_re),
        .i_den (r3_den),
        .o_quo (w_quo_re),
        .o_sat (w_sat_re)
    );

    cau_div u_div_im (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r3_side.mag_im),
        .i_den (r3_den),
        .o_quo (w_quo_im),
        .o_sat (w_sat_im)
    );

    // Carry sign, magnitude and flags alongside the divider
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side[0] <= r3_side;
            for (int k = 1; k < DIV_STAGES; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // Output stage: pick the magnitude, saturate, register
    always_comb begin
        if (r_side[DIV_STAGES-1].mode == MODE_DIV) begin
            if (r_side[DIV_STAGES-1].dz) begin
                w_fmag_re = '0;
                w_fmag_im = '0;
            end else begin
                w_fmag_re = w_sat_re ? 64'h1_0000_0000 : 64'(w_quo_re);
                w_fmag_im = w_sat_im ? 64'h1_0000_0000 : 64'(w_quo_im);
            end
        end else begin
            w_fmag_re = r_side[DIV_STAGES-1].mag_re;
            w_fmag_im = r_side[DIV_STAGES-1].mag_im;
        end
    end

    assign w_sat_out_re = sat32(r_side[DIV_STAGES-1].neg_re, w_fmag_re);
    assign w_sat_out_im = sat32(r_side[DIV_STAGES-1].neg_im, w_fmag_im);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out.res_re      <= w_sat_out_re[31:0];
            r_out.res_im      <= w_sat_out_im[31:0];
            r_out.div_by_zero <= r_side[DIV_STAGES-1].dz;
            r_out.overflow    <= w_sat_out_re[32] | w_sat_out_im[32];
        end
    end

    // A divide by zero shows a zero result without overflow
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.div_by_zero) |->
        (o_data.res_re == 32'sh0 && o_data.res_im == 32'sh0 && !o_data.overflow))
        else $error("divide by zero result not cleared");

    // Overflow only with a part at a range limit
    a_ovf_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.overflow) |->
        (o_data.res_re == 32'sh7FFF_FFFF || o_data.res_re == -32'sh8000_0000 ||
         o_data.res_im == 32'sh7FFF_FFFF || o_data.res_im == -32'sh8000_0000))
        else $error("overflow without saturated part");

    // A held pipe keeps its valid bits
    a_hold_vld: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> (r_vld == $past(r_vld)))
        else $error("valid bits moved while held");

endmodule

// File: sim/complex_arith_unit_top_tb.sv
`timescale 1ns / 1ps

module complex_arith_unit_top_tb import cau_pkg::*; ();

    localparam int N_RANDOM    = 1100;
    localparam int WDOG_LIMIT  = 20000;
    localparam int LATENCY     = 20;
    localparam logic [2:0] MODE_BAD6 = 3'd6;
    localparam logic [2:0] MODE_BAD7 = 3'd7;
    localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    t_in  i_data;
    logic o_valid;
    logic i_stall;
    t_out o_data;

    int  n_errors;
    bit  sending_done;
    bit  rx_hold;
    bit  long_hold_req;
    int  idle_cycles;

    complex_arith_unit_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    // 20 ns clock
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        n_errors++;
    endtask

    // Saturate a signed magnitude to Q16.16 and flag clipping
    function automatic logic [31:0] clip_q16(input bit neg, input logic [64:0] mag,
                                             inout bit ovf);
        if (!neg) begin
            if (mag > 65'h7FFF_FFFF) begin
                ovf = 1'b1;
                return Q_MAX;
            end
            return mag[31:0];
        end
        if (mag > 65'h8000_0000) begin
            ovf = 1'b1;
            return Q_MIN;
        end
        return 32'(-mag[31:0]);
    endfunction

    // Work out the result of one complex operation
    function automatic t_out complex_result(input t_in x);
        t_out r;
        logic signed [65:0] re_v, im_v, den, nre, nim;
        logic signed [63:0] ar, ai, br, bi;
        logic [65:0] mag;
        logic [65:0] q;
        bit ovf;
        bit neg_re, neg_im;
        logic [64:0] mre, mim;
        ar = x.a_re;
        ai = x.a_im;
        br = x.b_re;
        bi = x.b_im;
        ovf = 1'b0;
        re_v = 0;
        im_v = 0;
        r = '0;
        case (x.mode)
            MODE_ADD: begin
                re_v = ar + br;
                im_v = ai + bi;
            end
            MODE_SUB: begin
                re_v = ar - br;
                im_v = ai - bi;
            end
            MODE_NEG: begin
                re_v = -ar;
                im_v = -ai;
            end
            MODE_CONJ: begin
                re_v = ar;
                im_v = -ai;
            end
            default: ;
        endcase
        neg_re = re_v < 0;
        neg_im = im_v < 0;
        mre = neg_re ? 65'(-re_v) : 65'(re_v);
        mim = neg_im ? 65'(-im_v) : 65'(im_v);
        if (x.mode == MODE_MUL) begin
            re_v = ar * br - ai * bi;
            im_v = ar * bi + ai * br;
            neg_re = re_v < 0;
            neg_im = im_v < 0;
            mag = neg_re ? -re_v : re_v;
            mre = 65'(mag >> 16);
            mag = neg_im ? -im_v : im_v;
            mim = 65'(mag >> 16);
        end else if (x.mode == MODE_DIV) begin
            den = br * br + bi * bi;
            if (den == 0) begin
                r.div_by_zero = 1'b1;
                mre = 0;
                mim = 0;
                neg_re = 0;
                neg_im = 0;
            end else begin
                nre = ar * br + ai * bi;
                nim = ai * br - ar * bi;
                neg_re = nre < 0;
                neg_im = nim < 0;
                mag = neg_re ? -nre : nre;
                q = {mag, 16'b0} / {16'b0, den};
                mre = (q >= 66'h1_0000_0000) ? 65'h1_0000_0000 : 65'(q);
                mag = neg_im ? -nim : nim;
                q = {mag, 16'b0} / {16'b0, den};
                mim = (q >= 66'h1_0000_0000) ? 65'h1_0000_0000 : 65'(q);
            end
        end
        r.res_re = clip_q16(neg_re, mre, ovf);
        r.res_im = clip_q16(neg_im, mim, ovf);
        r.overflow = ovf;
        return r;
    endfunction

    class result_board;
        t_out pending[$];

        function void note_operands(input t_in x);
            pending.push_back(complex_result(x));
        endfunction

        task check_result(input t_out got);
            t_out want;
            if (pending.size() == 0) begin
                report_mismatch("unexpected result", got.res_re, 32'h0);
                return;
            end
            want = pending.pop_front();
            if (got.res_re !== want.res_re)
                report_mismatch("res_re", got.res_re, want.res_re);
            if (got.res_im !== want.res_im)
                report_mismatch("res_im", got.res_im, want.res_im);
            if (got.div_by_zero !== want.div_by_zero)
                report_mismatch("div_by_zero", 32'(got.div_by_zero), 32'(want.div_by_zero));
            if (got.overflow !== want.overflow)
                report_mismatch("overflow", 32'(got.overflow), 32'(want.overflow));
        endtask
    endclass

    result_board board;

    // Offer one item and hold it until the transfer
    task automatic send_item(input t_in x);
        int gap;
        gap = $urandom_range(0, 6);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= x;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        board.note_operands(x);
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return Q_MAX;
            1: return Q_MIN;
            2: return 32'($urandom_range(0, 4)) << 16;
            3: return 32'($signed($urandom_range(0, 131071)) - 65536);
            4: return 32'(-$signed(32'($urandom_range(0, 8)) << 16));
            default: return $urandom;
        endcase
    endfunction

    function automatic t_in rand_item();
        t_in x;
        x.mode = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                               : 3'($urandom_range(0, 5));
        x.a_re = rand_word();
        x.a_im = rand_word();
        x.b_re = rand_word();
        x.b_im = rand_word();
        if (x.mode == MODE_DIV && $urandom_range(0, 9) == 0) begin
            x.b_re = '0;
            x.b_im = '0;
        end
        return x;
    endfunction

    function automatic t_in mk(input logic [2:0] m, input logic [31:0] ar,
                               input logic [31:0] ai, input logic [31:0] br,
                               input logic [31:0] bi);
        t_in x;
        x.mode = m;
        x.a_re = ar;
        x.a_im = ai;
        x.b_re = br;
        x.b_im = bi;
        return x;
    endfunction

    // Stimulus
    initial begin
        board = new();
        n_errors = 0;
        sending_done = 1'b0;
        long_hold_req = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data  = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed corners
        send_item(mk(MODE_ADD, Q_MAX, Q_MIN, Q_MAX, Q_MIN));
        send_item(mk(MODE_ADD, Q_ONE, -Q_ONE, Q_ONE, Q_ONE));
        send_item(mk(MODE_SUB, Q_MIN, Q_MAX, Q_MAX, Q_MIN));
        send_item(mk(MODE_SUB, Q_ONE, Q_ONE, Q_ONE, Q_ONE));
        send_item(mk(MODE_MUL, Q_MAX, Q_MAX, Q_MAX, Q_MIN));
        send_item(mk(MODE_MUL, Q_MIN, Q_MIN, Q_MIN, Q_MIN));
        send_item(mk(MODE_MUL, Q_ONE, Q_ONE, -Q_ONE, Q_ONE));
        send_item(mk(MODE_MUL, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0003, 32'h0000_0001));
        send_item(mk(MODE_DIV, Q_ONE, 0, 0, 0));
        send_item(mk(MODE_DIV, Q_MAX, Q_MIN, 0, 0));
        send_item(mk(MODE_DIV, Q_MAX, Q_MAX, 32'h1, 0));
        send_item(mk(MODE_DIV, Q_ONE, Q_ONE, Q_ONE, -Q_ONE));
        send_item(mk(MODE_DIV, Q_MIN, Q_MIN, Q_MIN, Q_MIN));
        send_item(mk(MODE_DIV, -Q_ONE, 32'h3, Q_MAX, 32'h7));
        send_item(mk(MODE_NEG, Q_MIN, Q_MAX, Q_ONE, Q_ONE));
        send_item(mk(MODE_NEG, 0, Q_MIN, 0, 0));
        send_item(mk(MODE_CONJ, Q_MIN, Q_MIN, Q_MAX, Q_MAX));
        send_item(mk(MODE_CONJ, Q_MAX, -Q_ONE, 0, 0));
        send_item(mk(MODE_BAD6, Q_MAX, Q_MIN, Q_ONE, Q_ONE));
        send_item(mk(MODE_BAD7, Q_MIN, Q_MAX, 0, 0));

        // Random stream, with a long receiver hold and a full drain partway
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == 300)
                long_hold_req = 1'b1;
            if (n == 700) begin
                i_valid <= 1'b0;
                @(negedge i_clk);
                while (board.pending.size() != 0)
                    @(negedge i_clk);
            end
            send_item(rand_item());
        end
        i_valid <= 1'b0;
        sending_done = 1'b1;
    end

    // Random receiver stall, with a one-off long hold
    initial begin
        int hold;
        i_stall = 1'b0;
        rx_hold = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (long_hold_req && !rx_hold) begin
                rx_hold = 1'b1;
                i_stall <= 1'b1;
                repeat (200) @(negedge i_clk);
            end
            hold = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold - 1) @(negedge i_clk);
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Check transfers on the output
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            board.check_result(o_data);
    end

    // Watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("** complex_arith_unit_top: FAILED **");
            $finish;
        end
    end

    // Drain, settle and conclude
    initial begin
        wait (sending_done);
        while (board.pending.size() != 0)
            @(posedge i_clk);
        repeat (LATENCY * 4) @(posedge i_clk);
        if (n_errors == 0 && board.pending.size() == 0)
            $display("** complex_arith_unit_top: PASSED **");
        else
            $display("** complex_arith_unit_top: FAILED **");
        $finish;
    end

endmodule
